/* rtl/lsbf_pkg.sv */
package lsbf_pkg;

    localparam int PIX_W      = 16;
    localparam int SW_W       = 11;
    localparam int STEP_W     = 14;
    localparam int PHASE_W    = 10;
    localparam int OW_W       = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam int SW_MAX     = 1024;
    localparam int MAX_REPEAT = 8;
    localparam int COPY_W     = $clog2(MAX_REPEAT + 1);
    localparam int SKIP_W     = 4;
    localparam logic [SKIP_W-1:0] SKIP_MAX = 4'hF;

    // phase search over the repeat cap: one bit of the step multiple per cycle
    localparam int JUMP_BITS  = $clog2(SW_MAX);
    localparam int JUMP_W     = PHASE_W + JUMP_BITS;
    localparam int JCNT_W     = $clog2(JUMP_BITS);

    // config division: one quotient bit per cycle
    localparam int DIV_STEPS  = STEP_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PHASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_BYTES    = 3'd5;

    typedef struct packed {
        logic [SW_W-1:0]    sw;
        logic [STEP_W-1:0]  qs;
        logic [PHASE_W-1:0] rs;
        logic [PHASE_W-1:0] qp;
        logic [PHASE_W-1:0] rp;
        logic [OW_W-1:0]    out_width;
        logic               filter;
        logic               swap;
        logic               busy;
    } cfg_t;

    typedef struct packed {
        logic             clr;
        logic             copy;
        logic [PIX_W-1:0] px;
        logic             rep;
        logic             last;
    } cmd_t;

    function automatic logic [PIX_W-1:0] swap16(input logic [PIX_W-1:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic logic [PIX_W-1:0] blend565(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [5:0]       r;
        logic [6:0]       g;
        logic [5:0]       bl;
        x  = swap16(a);
        y  = swap16(b);
        r  = {1'b0, x[15:11]} + {1'b0, y[15:11]};
        g  = {1'b0, x[10:5]} + {1'b0, y[10:5]};
        bl = {1'b0, x[4:0]} + {1'b0, y[4:0]};
        return swap16({r[5:1], g[6:1], bl[5:1]});
    endfunction

endpackage

/* rtl/lsbf_cfg.sv */
module lsbf_cfg import lsbf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [SW_W-1:0]    sw_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [PHASE_W-1:0] start_reg;
    logic [OW_W-1:0]    ow_reg;
    logic               filt_reg;
    logic               swap_reg;
    logic               load_reg, load_next;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    logic [STEP_W-1:0]  qa_reg, qa_next, qb_reg, qb_next;
    logic [SW_W-1:0]    ra_reg, ra_next, rb_reg, rb_next;

    logic [SW_W-1:0]    sw_eff;
    logic [STEP_W-1:0]  step_eff;
    logic [SW_W:0]      ta, tb;
    logic               ga, gb;

    always_comb begin
        if (sw_reg == '0) begin
            sw_eff = SW_W'(1);
        end else if (sw_reg > SW_W'(SW_MAX)) begin
            sw_eff = SW_W'(SW_MAX);
        end else begin
            sw_eff = sw_reg;
        end
        step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;

        ta = {ra_reg, qa_reg[STEP_W-1]};
        tb = {rb_reg, qb_reg[STEP_W-1]};
        ga = ta >= {1'b0, sw_eff};
        gb = tb >= {1'b0, sw_eff};

        load_next = load_reg;
        cnt_next  = cnt_reg;
        qa_next   = qa_reg;
        ra_next   = ra_reg;
        qb_next   = qb_reg;
        rb_next   = rb_reg;
        if (load_reg) begin
            qa_next   = step_eff;
            ra_next   = '0;
            qb_next   = STEP_W'(start_reg);
            rb_next   = '0;
            cnt_next  = DCNT_W'(DIV_STEPS);
            load_next = 1'b0;
        end else if (cnt_reg != '0) begin
            // one restoring step per lane, same divisor
            ra_next  = ga ? SW_W'(ta - {1'b0, sw_eff}) : ta[SW_W-1:0];
            rb_next  = gb ? SW_W'(tb - {1'b0, sw_eff}) : tb[SW_W-1:0];
            qa_next  = {qa_reg[STEP_W-2:0], ga};
            qb_next  = {qb_reg[STEP_W-2:0], gb};
            cnt_next = cnt_reg - DCNT_W'(1);
        end
        if (cfg_we) begin
            load_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg    <= SW_W'(320);
            step_reg  <= STEP_W'(320);
            start_reg <= '0;
            ow_reg    <= OW_W'(320);
            filt_reg  <= 1'b0;
            swap_reg  <= 1'b0;
            load_reg  <= 1'b0;
            cnt_reg   <= '0;
            qa_reg    <= STEP_W'(1);
            ra_reg    <= '0;
            qb_reg    <= '0;
            rb_reg    <= '0;
        end else begin
            load_reg <= load_next;
            cnt_reg  <= cnt_next;
            qa_reg   <= qa_next;
            ra_reg   <= ra_next;
            qb_reg   <= qb_next;
            rb_reg   <= rb_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_SCREEN_WIDTH:  sw_reg    <= cfg_data[SW_W-1:0];
                    REG_X_STEP:        step_reg  <= cfg_data[STEP_W-1:0];
                    REG_START_PHASE:   start_reg <= cfg_data[PHASE_W-1:0];
                    REG_OUT_WIDTH:     ow_reg    <= cfg_data[OW_W-1:0];
                    REG_FILTER_ENABLE: filt_reg  <= cfg_data[0];
                    REG_SWAP_BYTES:    swap_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg.sw        = sw_eff;
    assign cfg.qs        = qa_reg;
    assign cfg.rs        = ra_reg[PHASE_W-1:0];
    assign cfg.qp        = qb_reg[PHASE_W-1:0];
    assign cfg.rp        = rb_reg[PHASE_W-1:0];
    assign cfg.out_width = ow_reg;
    assign cfg.filter    = filt_reg;
    assign cfg.swap      = swap_reg;
    assign cfg.busy      = load_reg | (cnt_reg != '0);

endmodule

/* rtl/lsbf_front.sv */
module lsbf_front import lsbf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_pixel,
    input  logic             s_line_start,
    input  logic             q_full,
    output logic             q_push,
    output cmd_t             q_cmd
);

    localparam logic [1:0] FS_COPY = 2'd0;
    localparam logic [1:0] FS_JUMP = 2'd1;
    localparam logic [1:0] FS_FIX  = 2'd2;

    logic               in_valid_reg, in_valid_next;
    logic [PIX_W-1:0]   in_px_reg, in_px_next;
    logic               in_ls_reg, in_ls_next;
    logic               first_reg, first_next;
    logic [1:0]         state_reg, state_next;
    logic [COPY_W-1:0]  copies_reg, copies_next;
    logic [JCNT_W-1:0]  bit_reg, bit_next;
    logic [PHASE_W-1:0] p_reg, p_next;
    logic [PHASE_W-1:0] hi_reg, hi_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic [OW_W-1:0]    outc_reg, outc_next;

    logic               ls_now, drop_full, is_last, carry, wrap, jfit, done;
    logic [PHASE_W-1:0] p_c, hi_c;
    logic [SKIP_W-1:0]  skip_c, skip_sat;
    logic [OW_W-1:0]    outc_c, outc_n;
    logic [COPY_W-1:0]  copies_n;
    logic [PIX_W-1:0]   px_sw;
    logic [SW_W-1:0]    sum1, rem1, fsum;
    logic [STEP_W:0]    adv, adv_m1;
    logic [JUMP_W-1:0]  jsum;

    always_comb begin
        // a line start reloads the line state before the item is classified
        ls_now    = in_ls_reg & first_reg;
        p_c       = ls_now ? cfg.rp : p_reg;
        hi_c      = ls_now ? cfg.qp : hi_reg;
        skip_c    = ls_now ? '0 : skip_reg;
        outc_c    = ls_now ? '0 : outc_reg;
        px_sw     = cfg.swap ? swap16(in_px_reg) : in_px_reg;
        drop_full = outc_c >= cfg.out_width;
        outc_n    = outc_c + OW_W'(1);
        copies_n  = copies_reg + COPY_W'(1);
        is_last   = outc_n >= cfg.out_width;

        sum1     = {1'b0, p_c} + {1'b0, cfg.rs};
        carry    = sum1 >= cfg.sw;
        rem1     = carry ? (sum1 - cfg.sw) : sum1;
        wrap     = carry | (|hi_c) | (|cfg.qs);
        adv      = (STEP_W+1)'(hi_c) + (STEP_W+1)'(cfg.qs) + (STEP_W+1)'(carry);
        adv_m1   = adv - (STEP_W+1)'(1);
        skip_sat = (|adv_m1[STEP_W:SKIP_W]) ? SKIP_MAX : adv_m1[SKIP_W-1:0];

        jsum = JUMP_W'(p_reg) + (JUMP_W'(cfg.rs) << bit_reg);
        jfit = jsum < JUMP_W'(cfg.sw);
        fsum = {1'b0, p_reg} + {1'b0, cfg.rs} - cfg.sw;

        in_valid_next = in_valid_reg;
        in_px_next    = in_px_reg;
        in_ls_next    = in_ls_reg;
        first_next    = first_reg;
        state_next    = state_reg;
        copies_next   = copies_reg;
        bit_next      = bit_reg;
        p_next        = p_reg;
        hi_next       = hi_reg;
        skip_next     = skip_reg;
        outc_next     = outc_reg;
        q_push        = 1'b0;
        q_cmd         = '{clr: ls_now, copy: 1'b1, px: px_sw,
                          rep: copies_n > COPY_W'(1), last: is_last};
        done          = 1'b0;

        if (in_valid_reg) begin
            unique case (state_reg)
                FS_COPY: begin
                    if (first_reg && drop_full) begin
                        // line complete: drop, but on a line start still push a command that discards the held pixel
                        if (!ls_now || !q_full) begin
                            q_push     = ls_now;
                            q_cmd.copy = 1'b0;
                            p_next     = p_c;
                            hi_next    = hi_c;
                            skip_next  = skip_c;
                            outc_next  = outc_c;
                            done       = 1'b1;
                        end
                    end else if (first_reg && skip_c != '0) begin
                        skip_next = skip_c - SKIP_W'(1);
                        done      = 1'b1;
                    end else if (!q_full) begin
                        q_push      = 1'b1;
                        outc_next   = outc_n;
                        copies_next = copies_n;
                        first_next  = 1'b0;
                        p_next      = p_c;
                        hi_next     = hi_c;
                        skip_next   = skip_c;
                        if (is_last) begin
                            done = 1'b1;
                        end else if (wrap) begin
                            p_next    = rem1[PHASE_W-1:0];
                            hi_next   = '0;
                            skip_next = skip_sat;
                            done      = 1'b1;
                        end else begin
                            p_next = sum1[PHASE_W-1:0];
                            if (copies_n == COPY_W'(MAX_REPEAT)) begin
                                state_next = FS_JUMP;
                                bit_next   = JCNT_W'(JUMP_BITS - 1);
                            end
                        end
                    end
                end
                FS_JUMP: begin
                    // largest phase below the width on the step progression
                    if (jfit) begin
                        p_next = jsum[PHASE_W-1:0];
                    end
                    if (bit_reg == '0) begin
                        state_next = FS_FIX;
                    end else begin
                        bit_next = bit_reg - JCNT_W'(1);
                    end
                end
                FS_FIX: begin
                    p_next     = fsum[PHASE_W-1:0];
                    skip_next  = '0;
                    state_next = FS_COPY;
                    done       = 1'b1;
                end
                default: state_next = FS_COPY;
            endcase
        end

        s_ready = !cfg.busy && (!in_valid_reg || done);
        if (done) begin
            in_valid_next = 1'b0;
            copies_next   = '0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_px_next    = s_pixel;
            in_ls_next    = s_line_start;
            first_next    = 1'b1;
            copies_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            first_reg    <= 1'b0;
            state_reg    <= FS_COPY;
            copies_reg   <= '0;
            bit_reg      <= '0;
            p_reg        <= '0;
            hi_reg       <= '0;
            skip_reg     <= '0;
            outc_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            first_reg    <= first_next;
            state_reg    <= state_next;
            copies_reg   <= copies_next;
            bit_reg      <= bit_next;
            p_reg        <= p_next;
            hi_reg       <= hi_next;
            skip_reg     <= skip_next;
            outc_reg     <= outc_next;
        end
        in_px_reg <= in_px_next;
        in_ls_reg <= in_ls_next;
    end

endmodule

/* rtl/lsbf_fifo.sv */
module lsbf_fifo import lsbf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic pop,
    output logic rd_valid,
    output cmd_t rd_cmd
);

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full     = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/lsbf_back.sv */
module lsbf_back import lsbf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             filter_enable,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_pixel_out,
    output logic             m_line_end
);

    logic [PIX_W-1:0] held_px_reg, held_px_next;
    logic             held_rep_reg, held_rep_next;
    logic             held_valid_reg, held_valid_next;
    logic [PIX_W-1:0] last_reg, last_next;
    logic             pend_reg, pend_next;
    logic             m_valid_reg, m_valid_next;
    logic [PIX_W-1:0] m_px_reg, m_px_next;
    logic             m_end_reg, m_end_next;

    logic             out_free, hv;
    logic [PIX_W-1:0] rel_px;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        hv       = held_valid_reg && !q_cmd.clr;
        rel_px   = (filter_enable && held_rep_reg) ? blend565(last_reg, q_cmd.px)
                                                   : held_px_reg;

        held_px_next    = held_px_reg;
        held_rep_next   = held_rep_reg;
        held_valid_next = held_valid_reg;
        last_next       = last_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_px_next       = m_px_reg;
        m_end_next      = m_end_reg;
        q_pop           = 1'b0;

        if (q_valid) begin
            if (!q_cmd.copy) begin
                held_valid_next = 1'b0;
                q_pop           = 1'b1;
            end else if (pend_reg) begin
                // second result of a line's last copy
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_px_next    = q_cmd.px;
                    m_end_next   = 1'b1;
                    last_next    = q_cmd.px;
                    pend_next    = 1'b0;
                    q_pop        = 1'b1;
                end
            end else if (hv) begin
                // release the held pixel now that its right neighbor is known
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_px_next    = rel_px;
                    m_end_next   = 1'b0;
                    last_next    = rel_px;
                    if (q_cmd.last) begin
                        held_valid_next = 1'b0;
                        pend_next       = 1'b1;
                    end else begin
                        held_px_next    = q_cmd.px;
                        held_rep_next   = q_cmd.rep;
                        held_valid_next = 1'b1;
                        q_pop           = 1'b1;
                    end
                end
            end else if (q_cmd.last) begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_px_next       = q_cmd.px;
                    m_end_next      = 1'b1;
                    last_next       = q_cmd.px;
                    held_valid_next = 1'b0;
                    q_pop           = 1'b1;
                end
            end else begin
                held_px_next    = q_cmd.px;
                held_rep_next   = q_cmd.rep;
                held_valid_next = 1'b1;
                q_pop           = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            last_reg       <= '0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            last_reg       <= last_next;
            pend_reg       <= pend_next;
            m_valid_reg    <= m_valid_next;
        end
        held_px_reg  <= held_px_next;
        held_rep_reg <= held_rep_next;
        m_px_reg     <= m_px_next;
        m_end_reg    <= m_end_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_px_reg;
    assign m_line_end  = m_end_reg;

endmodule

/* rtl/line_scaler_with_blend_filter_core.sv */
// Throughput: the front makes one output copy per cycle while the queue is not full;
// the repeat cap adds a phase search; the back emits one result per cycle while
// m_ready holds. A config write runs a division with s_ready low.
// Reset: aresetn is synchronous, active low; registers return to their reset values.
module line_scaler_with_blend_filter_core import lsbf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,
    input  logic                  s_line_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_pixel_out,
    output logic                  m_line_end
);

    cfg_t cfg_bus;
    cmd_t push_cmd, head_cmd;
    logic q_push, q_full, q_pop, q_valid;

    lsbf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg_bus)
    );

    lsbf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_bus),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .s_line_start (s_line_start),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    lsbf_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_cmd   (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (head_cmd)
    );

    lsbf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .filter_enable (cfg_bus.filter),
        .q_valid       (q_valid),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_line_end    (m_line_end)
    );

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_bus.busy |-> !s_ready)
        else $error("item accepted while config division runs");

    a_write_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> cfg_bus.busy)
        else $error("config write did not start division");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

endmodule

/* tb/tb_line_scaler_with_blend_filter_core.sv */
`timescale 1ns / 1ps

module tb_line_scaler_with_blend_filter_core;
    import lsbf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYC   = 40;
    localparam int CFG_GAP      = 20;
    localparam int TARGET_ITEMS = 380;
    localparam int MAX_LINE_SRC = 48;
    localparam int MAX_REPORTS  = 50;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic             ls;
    } src_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic             last;
    } out_pix_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel      = '0;
    logic                  s_line_start = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [PIX_W-1:0]      m_pixel_out;
    logic                  m_line_end;

    line_scaler_with_blend_filter_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .s_line_start (s_line_start),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_line_end   (m_line_end)
    );

    // register copies used for prediction
    int unsigned      c_width;
    int unsigned      c_step;
    int unsigned      c_start;
    int unsigned      c_outw;
    logic             c_filter;
    logic             c_swap;

    // line state of the predictor
    int unsigned      acc_phase;
    int unsigned      skip_left;
    int unsigned      outs_done;
    logic [PIX_W-1:0] pend_px;
    logic             pend_rep;
    logic             pend_valid;
    logic [PIX_W-1:0] last_out;

    src_item_t        src_items[$];
    out_pix_t         expected_pix[$];
    src_item_t        next_src;
    out_pix_t         want;

    int unsigned      pushed_cnt;
    int unsigned      sent_cnt;
    int unsigned      acc_cnt;
    int unsigned      checked_cnt;
    int unsigned      err_cnt;
    int unsigned      cfg_cnt;
    int unsigned      cycles;
    int               gap_left;
    int               stall_left;
    logic             calm = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Pixel words carry RGB565 with bytes swapped: red 7:3, green 2:0 and 15:13, blue 12:8.
    function automatic logic [PIX_W-1:0] blend_bus_words(input logic [PIX_W-1:0] a,
                                                         input logic [PIX_W-1:0] b);
        logic [5:0] r;
        logic [6:0] g;
        logic [5:0] bl;
        r  = {1'b0, a[7:3]} + {1'b0, b[7:3]};
        g  = {1'b0, a[2:0], a[15:13]} + {1'b0, b[2:0], b[15:13]};
        bl = {1'b0, a[12:8]} + {1'b0, b[12:8]};
        return {g[3:1], bl[5:1], r[5:1], g[6:4]};
    endfunction

    function automatic void emit(input logic [PIX_W-1:0] px, input logic last);
        out_pix_t o;
        o.px   = px;
        o.last = last;
        expected_pix.push_back(o);
        last_out = px;
    endfunction

    function automatic void scale_item(input logic [PIX_W-1:0] pix, input logic ls);
        logic [PIX_W-1:0] px;
        int unsigned      sw;
        int unsigned      st;
        int unsigned      copies;
        int unsigned      adv;
        logic             done;
        px = c_swap ? {pix[7:0], pix[15:8]} : pix;
        sw = (c_width == 0) ? 1 : ((c_width > SW_MAX) ? SW_MAX : c_width);
        st = (c_step == 0) ? 1 : c_step;
        if (ls) begin
            acc_phase  = c_start;
            skip_left  = 0;
            outs_done  = 0;
            pend_valid = 1'b0;
            pend_rep   = 1'b0;
        end
        if (outs_done >= c_outw)
            return;
        if (skip_left > 0) begin
            skip_left--;
            return;
        end
        copies = 0;
        done   = 1'b0;
        while (!done) begin
            if (pend_valid) begin
                emit((c_filter && pend_rep) ? blend_bus_words(last_out, px) : pend_px, 1'b0);
                pend_valid = 1'b0;
            end
            outs_done++;
            copies++;
            if (outs_done >= c_outw) begin
                emit(px, 1'b1);
                done = 1'b1;
            end else begin
                pend_px    = px;
                pend_rep   = (copies > 1);
                pend_valid = 1'b1;
                acc_phase += st;
                // repeat cap: jump to the first phase at or past the modulus
                if (acc_phase < sw && copies >= MAX_REPEAT)
                    acc_phase += ((sw - acc_phase + st - 1) / st) * st;
                if (acc_phase >= sw) begin
                    adv       = acc_phase / sw;
                    acc_phase = acc_phase % sw;
                    skip_left = (adv - 1 > SKIP_MAX) ? SKIP_MAX : adv - 1;
                    done      = 1'b1;
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] exp_val);
        if (err_cnt < MAX_REPORTS)
            $display("mismatch at %0t: %s got %h, expected %h", $time, what, got, exp_val);
        err_cnt++;
    endtask

    // driver: hold the item until accepted, then pick the next one or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || sent_cnt == acc_cnt) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (src_items.size() > 0) begin
                next_src = src_items.pop_front();
                s_valid      <= 1'b1;
                s_pixel      <= next_src.px;
                s_line_start <= next_src.ls;
                sent_cnt++;
                if (!calm && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 10);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                scale_item(s_pixel, s_line_start);
                acc_cnt++;
            end
            if (m_valid && m_ready) begin
                if (expected_pix.size() == 0) begin
                    report_mismatch("unexpected result, pixel_out", m_pixel_out, '0);
                end else begin
                    want = expected_pix.pop_front();
                    checked_cnt++;
                    if (m_pixel_out !== want.px)
                        report_mismatch("pixel_out", m_pixel_out, want.px);
                    if (m_line_end !== want.last)
                        report_mismatch("line_end", {15'd0, m_line_end}, {15'd0, want.last});
                end
            end
        end
    end

    task automatic push_src(input logic [PIX_W-1:0] px, input logic ls);
        src_item_t it;
        it.px = px;
        it.ls = ls;
        src_items.push_back(it);
        pushed_cnt++;
    endtask

    task automatic push_line(input int unsigned n, input logic with_start);
        for (int unsigned i = 0; i < n; i++)
            push_src($urandom, with_start && (i == 0));
    endtask

    task automatic wait_drain();
        while (acc_cnt != pushed_cnt || expected_pix.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        repeat (CFG_GAP) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_SCREEN_WIDTH:  c_width  = val[SW_W-1:0];
            REG_X_STEP:        c_step   = val[STEP_W-1:0];
            REG_START_PHASE:   c_start  = val[PHASE_W-1:0];
            REG_OUT_WIDTH:     c_outw   = val[OW_W-1:0];
            REG_FILTER_ENABLE: c_filter = val[0];
            REG_SWAP_BYTES:    c_swap   = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        cfg_cnt++;
    endtask

    task automatic apply_cfg(input int unsigned sw, input int unsigned st,
                             input int unsigned start, input int unsigned outw,
                             input int unsigned filt, input int unsigned swp);
        wait_drain();
        write_reg(REG_SCREEN_WIDTH, sw);
        write_reg(REG_X_STEP, st);
        write_reg(REG_START_PHASE, start);
        write_reg(REG_OUT_WIDTH, outw);
        write_reg(REG_FILTER_ENABLE, filt);
        write_reg(REG_SWAP_BYTES, swp);
    endtask

    initial begin
        int unsigned cw;
        int unsigned cs;
        int unsigned cst;
        int unsigned co;
        int unsigned sw_e;
        int unsigned st_e;
        int unsigned n;
        int unsigned in_phase;
        int unsigned target;
        int unsigned phase_no;

        c_width    = 320;
        c_step     = 320;
        c_start    = 0;
        c_outw     = 320;
        c_filter   = 1'b0;
        c_swap     = 1'b0;
        acc_phase  = 0;
        skip_left  = 0;
        outs_done  = 0;
        pend_px    = '0;
        pend_rep   = 1'b0;
        pend_valid = 1'b0;
        last_out   = '0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings, no line start yet; the line start then drops the held pixel
        push_src(16'h0000, 1'b0);
        push_src(16'hFFFF, 1'b0);
        push_src(16'hA55A, 1'b0);
        push_src(16'h5AA5, 1'b1);

        // 4x repeat with blend and byte swap, one pixel past the line end
        apply_cfg(4, 1, 0, 12, 1, 1);
        push_src(16'hFFFF, 1'b1);
        push_src(16'h0000, 1'b0);
        push_src(16'h1234, 1'b0);
        push_src(16'h5678, 1'b0);

        // repeat cap hit on the first pixel
        apply_cfg(SW_MAX, 1, 0, 10, 1, 0);
        push_src(16'h8000, 1'b1);
        push_src(16'h001F, 1'b0);
        push_src(16'h7BEF, 1'b0);

        // skip count saturates, start phase at its top
        apply_cfg(1, 17, 1023, 2, 0, 0);
        push_line(17, 1'b1);

        // zero step and zero width act as one
        apply_cfg(0, 0, 5, 1, 1, 1);
        push_src($urandom, 1'b1);
        push_src($urandom, 1'b0);

        // zero out width, width above range, step with only its top bit set
        apply_cfg(2047, 8192, 0, 0, 0, 0);
        push_src($urandom, 1'b1);

        phase_no = 0;
        while (pushed_cnt < TARGET_ITEMS) begin
            calm = (pushed_cnt >= TARGET_ITEMS - 50);
            if (phase_no == 3) begin
                // widest line: 8x upscale
                apply_cfg(SW_MAX, 128, 0, 512, 1, $urandom_range(0, 1));
                push_line(66, 1'b1);
            end else begin
                case ($urandom_range(0, 7))
                    0:       cw = 1;
                    1:       cw = SW_MAX;
                    2:       cw = 0;
                    3:       cw = $urandom_range(SW_MAX + 1, 2047);
                    default: cw = $urandom_range(1, SW_MAX);
                endcase
                sw_e = (cw == 0) ? 1 : ((cw > SW_MAX) ? SW_MAX : cw);
                case ($urandom_range(0, 7))
                    0:       cs = 1;
                    1:       cs = 8192;
                    2:       cs = 0;
                    3:       cs = $urandom_range(8193, 16383);
                    default: cs = (sw_e * $urandom_range(1, 40) + 15) / 16;
                endcase
                case ($urandom_range(0, 3))
                    0:       cst = 0;
                    1:       cst = 1023;
                    default: cst = $urandom_range(0, 1023);
                endcase
                co = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24);
                apply_cfg(cw, cs, cst, co, $urandom_range(0, 1), $urandom_range(0, 1));
                st_e = (cs == 0) ? 1 : cs;
                target = (co == 0) ? 1 : 30;
                in_phase = 0;
                while (in_phase < target) begin
                    // rough count of source pixels for a full line
                    n = (co * st_e + sw_e - 1) / sw_e;
                    if (n < (co + 7) / 8)
                        n = (co + 7) / 8;
                    if (n > co * 16)
                        n = co * 16;
                    n = n + $urandom_range(0, 2);
                    if (n == 0)
                        n = 1;
                    // cut some lines short so the next line start drops the held pixel
                    if ($urandom_range(0, 5) == 0)
                        n = $urandom_range(1, n);
                    if (n > MAX_LINE_SRC)
                        n = MAX_LINE_SRC;
                    push_line(n, $urandom_range(0, 9) != 0);
                    in_phase += n;
                    if ($urandom_range(0, 7) == 0)
                        wait_drain();
                end
            end
            phase_no++;
        end

        wait_drain();
        $display("covered %0d source items over %0d settings, %0d register writes",
                 acc_cnt, phase_no + 6, cfg_cnt);
        $display("checked %0d results in %0d cycles, %0d mismatches",
                 checked_cnt, cycles, err_cnt);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
